### hw/rtl/lcsc_pkg.sv
package lcsc_pkg;

    localparam int AVG_COUNT_DEF = 200;
    localparam int ADC_BITS_DEF  = 12;

    localparam int CAL_W    = 10;
    localparam int ALARM_W  = 23;
    localparam int WEIGHT_W = 24;
    localparam int QUOT_W   = 24;
    localparam int MODE_W   = 3;
    localparam int CNT_W    = 8;
    localparam int CG_W     = 7;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [CG_W-1:0] CG_PER_G = 7'd100;

    localparam logic [CAL_W-1:0]   CAL_MASS_RST  = 10'd100;
    localparam logic [ALARM_W-1:0] ALARM_ON_RST  = 23'd13000;
    localparam logic [ALARM_W-1:0] ALARM_OFF_RST = 23'd12000;

    localparam logic [1:0] REG_CAL_MASS  = 2'd0;
    localparam logic [1:0] REG_ALARM_ON  = 2'd1;
    localparam logic [1:0] REG_ALARM_OFF = 2'd2;

    localparam logic [MODE_W-1:0] M_IDLE     = 3'd0;
    localparam logic [MODE_W-1:0] M_AVG_ZERO = 3'd1;
    localparam logic [MODE_W-1:0] M_WAIT_SPN = 3'd2;
    localparam logic [MODE_W-1:0] M_AVG_SPAN = 3'd3;
    localparam logic [MODE_W-1:0] M_CONFIRM  = 3'd4;
    localparam logic [MODE_W-1:0] M_MEASURE  = 3'd5;
    localparam logic [MODE_W-1:0] M_TARE     = 3'd6;
    localparam logic [MODE_W-1:0] M_ALARM    = 3'd7;

    localparam logic signed [WEIGHT_W-1:0] W_MAX = 24'sh7FFFFF;
    localparam logic signed [WEIGHT_W-1:0] W_MIN = 24'sh800000;

    typedef struct packed {
        logic [CAL_W-1:0]   cal_mass;
        logic [ALARM_W-1:0] alarm_on;
        logic [ALARM_W-1:0] alarm_off;
    } cfg_t;

    typedef struct packed {
        logic              done;
        logic              ovf;
        logic [QUOT_W-1:0] quot;
    } div_res_t;

endpackage

### hw/rtl/load_cell_scale_controller_unit.sv
// Load cell scale controller. Each input transfer carries one converter sample and the
// action and reset button levels and yields exactly one result transfer with the net
// weight in centigrams, the mode, the LED and buzzer drives and the calibration error
// flag. An item is accepted in the idle state; offset, gain and scale arithmetic and the
// divider load take the states DIFF, MUL1, MUL2 and DIVGO, the bit-serial divider then
// gives 24 quotient bits, one per cycle, and its finish flag, and the GROSS and POST
// states do saturation, tare and mode update, the result being registered in POST. With
// equal references or a quotient beyond 24 bits the divider finishes at once. The input
// side is ready only while no item is in work; a finished result waits in the output
// register while the next item is accepted, and the next result is held back until that
// register is free. Configuration registers sit on the APB port at 0x0 (calibration mass,
// grams), 0x4 (alarm on level) and 0x8 (alarm off level).
module load_cell_scale_controller_unit
    import lcsc_pkg::*;
#(
    parameter int AVG_COUNT = AVG_COUNT_DEF,
    parameter int ADC_BITS  = ADC_BITS_DEF,
    parameter int S_DATA_W  = ((ADC_BITS + 7) / 8) * 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [ADC_BITS-1:0] adc_sample, rest zero
    input  logic [S_DATA_W-1:0] s_tdata,
    // [0] action_button, [1] reset_button
    input  logic [1:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [23:0] net_weight_cg, [26:24] mode_code, [27] red_led, [28] green_led,
    // [29] alarm_drive, [30] cal_error, [31] zero
    output logic [31:0]         m_tdata,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int REF_W = ADC_BITS + 8;
    localparam int P1_W  = REF_W + CAL_W;
    localparam int NUM_W = P1_W + CG_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIFF  = 3'd1;
    localparam logic [2:0] S_MUL1  = 3'd2;
    localparam logic [2:0] S_MUL2  = 3'd3;
    localparam logic [2:0] S_DIVGO = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_GROSS = 3'd6;
    localparam logic [2:0] S_POST  = 3'd7;

    cfg_t     cfg;
    div_res_t dres;

    logic [2:0] seq_reg, seq_next;

    logic [ADC_BITS-1:0] sample_reg;
    logic                act_reg;
    logic                rst_btn_reg;

    logic [REF_W-1:0] diff_mag_reg;
    logic             neg_reg;
    logic [REF_W-1:0] den_mag_reg;
    logic             den_zero_reg;
    logic [P1_W-1:0]  prod1_reg;
    logic [NUM_W-1:0] num_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic              ovf_reg;
    logic signed [WEIGHT_W-1:0] gross_reg;

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [REF_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [REF_W-1:0]  zero_reg, zero_next;
    logic [REF_W-1:0]  span_reg, span_next;
    logic signed [WEIGHT_W-1:0] tare_reg, tare_next;
    logic              red_reg, red_next;
    logic              buzz_reg, buzz_next;

    logic                       m_valid_reg;
    logic [31:0]                m_data_reg;

    logic                       accept;
    logic                       out_free;
    logic                       commit;
    logic [REF_W-1:0]           scaled;
    logic signed [REF_W:0]      diff;
    logic signed [REF_W:0]      den;
    logic signed [REF_W:0]      diff_abs;
    logic signed [REF_W:0]      den_abs;
    logic signed [WEIGHT_W-1:0] gross_calc;
    logic signed [WEIGHT_W:0]   net_wide;
    logic signed [WEIGHT_W-1:0] net;
    logic                       net_ge_on;
    logic                       net_lt_off;
    logic [REF_W-1:0]           sum_inc;
    logic [CNT_W:0]             cnt_inc;

    lcsc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lcsc_div #(
        .NUM_W (NUM_W),
        .DEN_W (REF_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (seq_reg == S_DIVGO),
        .num   (num_reg),
        .den   (den_mag_reg),
        .res   (dres)
    );

    assign s_tready = (seq_reg == S_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign commit   = (seq_reg == S_POST) && out_free;

    // sequencer
    always_comb
    begin
        seq_next = seq_reg;
        unique case (seq_reg)
            S_IDLE:  if (accept) seq_next = S_DIFF;
            S_DIFF:  seq_next = S_MUL1;
            S_MUL1:  seq_next = S_MUL2;
            S_MUL2:  seq_next = S_DIVGO;
            S_DIVGO: seq_next = S_DIV;
            S_DIV:   if (dres.done) seq_next = S_GROSS;
            S_GROSS: seq_next = S_POST;
            S_POST:  if (out_free) seq_next = S_IDLE;
            default: seq_next = S_IDLE;
        endcase
    end

    // offset and span differences
    assign scaled   = REF_W'(sample_reg) * REF_W'(AVG_COUNT);
    assign diff     = $signed({1'b0, scaled}) - $signed({1'b0, zero_reg});
    assign den      = $signed({1'b0, span_reg}) - $signed({1'b0, zero_reg});
    assign diff_abs = diff[REF_W] ? -diff : diff;
    assign den_abs  = den[REF_W] ? -den : den;

    // quotient to saturated gross
    always_comb
    begin
        if (den_zero_reg)
        begin
            gross_calc = '0;
        end
        else if (ovf_reg)
        begin
            gross_calc = neg_reg ? W_MIN : W_MAX;
        end
        else if (!neg_reg)
        begin
            gross_calc = quot_reg[QUOT_W-1] ? W_MAX : $signed(quot_reg);
        end
        else if (quot_reg[QUOT_W-1] && (quot_reg[QUOT_W-2:0] != '0))
        begin
            gross_calc = W_MIN;
        end
        else
        begin
            gross_calc = -$signed(quot_reg);
        end
    end

    assign net_wide = {gross_reg[WEIGHT_W-1], gross_reg} - {tare_reg[WEIGHT_W-1], tare_reg};

    always_comb
    begin
        if (net_wide[WEIGHT_W] != net_wide[WEIGHT_W-1])
        begin
            net = net_wide[WEIGHT_W] ? W_MIN : W_MAX;
        end
        else
        begin
            net = net_wide[WEIGHT_W-1:0];
        end
    end

    assign net_ge_on  = !net[WEIGHT_W-1] && (net[ALARM_W-1:0] >= cfg.alarm_on);
    assign net_lt_off = net[WEIGHT_W-1] || (net[ALARM_W-1:0] < cfg.alarm_off);

    assign sum_inc = sum_reg + REF_W'(sample_reg);
    assign cnt_inc = {1'b0, cnt_reg} + 1'b1;

    // mode update
    always_comb
    begin
        mode_next = mode_reg;
        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        zero_next = zero_reg;
        span_next = span_reg;
        tare_next = tare_reg;
        red_next  = red_reg;
        buzz_next = buzz_reg;
        if (rst_btn_reg)
        begin
            mode_next = M_IDLE;
            red_next  = 1'b1;
            buzz_next = 1'b0;
        end
        else
        begin
            unique case (mode_reg)
                M_IDLE:
                begin
                    red_next  = 1'b1;
                    buzz_next = 1'b0;
                    if (act_reg)
                    begin
                        sum_next  = '0;
                        cnt_next  = '0;
                        mode_next = M_AVG_ZERO;
                    end
                end
                M_AVG_ZERO, M_AVG_SPAN:
                begin
                    red_next  = !red_reg;
                    buzz_next = 1'b0;
                    sum_next  = sum_inc;
                    cnt_next  = cnt_inc[CNT_W-1:0];
                    if (cnt_inc >= (CNT_W + 1)'(AVG_COUNT))
                    begin
                        if (mode_reg == M_AVG_ZERO)
                        begin
                            zero_next = sum_inc;
                            mode_next = M_WAIT_SPN;
                        end
                        else
                        begin
                            span_next = sum_inc;
                            mode_next = M_CONFIRM;
                        end
                        sum_next = '0;
                        cnt_next = '0;
                    end
                end
                M_WAIT_SPN:
                begin
                    red_next  = !red_reg;
                    buzz_next = 1'b0;
                    if (act_reg)
                    begin
                        sum_next  = '0;
                        cnt_next  = '0;
                        mode_next = M_AVG_SPAN;
                    end
                end
                M_CONFIRM:
                begin
                    red_next  = act_reg ? 1'b0 : !red_reg;
                    buzz_next = 1'b0;
                    if (act_reg)
                    begin
                        mode_next = M_MEASURE;
                    end
                end
                M_MEASURE:
                begin
                    red_next  = 1'b0;
                    buzz_next = 1'b0;
                    if (act_reg)
                    begin
                        tare_next = gross_reg;
                        mode_next = M_TARE;
                    end
                    else if (net_ge_on)
                    begin
                        mode_next = M_ALARM;
                    end
                end
                M_TARE:
                begin
                    red_next  = 1'b0;
                    buzz_next = 1'b0;
                    mode_next = M_MEASURE;
                end
                M_ALARM:
                begin
                    if (net_lt_off)
                    begin
                        red_next  = 1'b0;
                        buzz_next = 1'b0;
                        mode_next = M_MEASURE;
                    end
                    else
                    begin
                        red_next  = !red_reg;
                        buzz_next = !buzz_reg;
                    end
                end
                default:
                begin
                    mode_next = M_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg     <= S_IDLE;
            mode_reg    <= M_IDLE;
            sum_reg     <= '0;
            cnt_reg     <= '0;
            zero_reg    <= '0;
            span_reg    <= '0;
            tare_reg    <= '0;
            red_reg     <= 1'b1;
            buzz_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg <= seq_next;
            if (commit)
            begin
                mode_reg <= mode_next;
                sum_reg  <= sum_next;
                cnt_reg  <= cnt_next;
                zero_reg <= zero_next;
                span_reg <= span_next;
                tare_reg <= tare_next;
                red_reg  <= red_next;
                buzz_reg <= buzz_next;
            end
            if (commit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg  <= s_tdata[ADC_BITS-1:0];
            act_reg     <= s_tuser[0];
            rst_btn_reg <= s_tuser[1];
        end
        if (seq_reg == S_DIFF)
        begin
            diff_mag_reg <= diff_abs[REF_W-1:0];
            den_mag_reg  <= den_abs[REF_W-1:0];
            neg_reg      <= diff[REF_W] ^ den[REF_W];
            den_zero_reg <= (span_reg == zero_reg);
        end
        if (seq_reg == S_MUL1)
        begin
            prod1_reg <= P1_W'(diff_mag_reg) * P1_W'(cfg.cal_mass);
        end
        if (seq_reg == S_MUL2)
        begin
            num_reg <= NUM_W'(prod1_reg) * NUM_W'(CG_PER_G);
        end
        if ((seq_reg == S_DIV) && dres.done)
        begin
            quot_reg <= dres.quot;
            ovf_reg  <= dres.ovf;
        end
        if (seq_reg == S_GROSS)
        begin
            gross_reg <= gross_calc;
        end
        if (commit)
        begin
            m_data_reg <= {1'b0, den_zero_reg, buzz_next,
                           (mode_next == M_MEASURE) || (mode_next == M_TARE),
                           red_next, mode_next, net};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        dres.done |-> (seq_reg == S_DIV))
        else $error("divider finished outside its wait state");

    a_red_off_measure: assert property (@(posedge clk) disable iff (!rst_n)
        ((mode_reg == M_MEASURE) || (mode_reg == M_TARE)) |-> !red_reg)
        else $error("red led on while measuring");

    a_buzz_only_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        buzz_reg |-> (mode_reg == M_ALARM))
        else $error("buzzer on outside alarm mode");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, cnt_reg} < (CNT_W + 1)'(AVG_COUNT)))
        else $error("sample count past averaging length");
`endif

endmodule

### hw/rtl/lcsc_regs.sv
module lcsc_regs
    import lcsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_CAL_MASS:  cfg_next.cal_mass  = pwdata[CAL_W-1:0];
                REG_ALARM_ON:  cfg_next.alarm_on  = pwdata[ALARM_W-1:0];
                REG_ALARM_OFF: cfg_next.alarm_off = pwdata[ALARM_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cal_mass  <= CAL_MASS_RST;
            cfg_reg.alarm_on  <= ALARM_ON_RST;
            cfg_reg.alarm_off <= ALARM_OFF_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_CAL_MASS:  prdata = APB_DW'(cfg_reg.cal_mass);
            REG_ALARM_ON:  prdata = APB_DW'(cfg_reg.alarm_on);
            REG_ALARM_OFF: prdata = APB_DW'(cfg_reg.alarm_off);
            default:       prdata = '0;
        endcase
    end

endmodule

### hw/rtl/lcsc_div.sv
module lcsc_div
    import lcsc_pkg::*;
#(
    parameter int NUM_W = 37,
    parameter int DEN_W = 20
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output div_res_t         res
);

    localparam int DSR_W = DEN_W + QUOT_W;
    localparam int CNT_DW = $clog2(QUOT_W);

    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [DSR_W-1:0]  dsr_reg, dsr_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [CNT_DW-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              ovf_reg, ovf_next;
    logic              ge;
    logic              ovf_in;

    assign ovf_in = DSR_W'(num) >= {den, QUOT_W'(0)};
    assign ge     = DSR_W'(rem_reg) >= dsr_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        if (start)
        begin
            rem_next  = num;
            dsr_next  = DSR_W'({den, (QUOT_W - 1)'(0)});
            quot_next = '0;
            cnt_next  = CNT_DW'(QUOT_W - 1);
            ovf_next  = ovf_in;
            busy_next = !ovf_in;
            done_next = ovf_in;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsr_reg[NUM_W-1:0];
            end
            quot_next = {quot_reg[QUOT_W-2:0], ge};
            dsr_next  = dsr_reg >> 1;
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        quot_reg <= quot_next;
        ovf_reg  <= ovf_next;
    end

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quot = quot_reg;

endmodule

### bench/load_cell_scale_controller_unit_tb.sv
module load_cell_scale_controller_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lcsc_pkg::*;

    localparam int S_DATA_W    = ((ADC_BITS_DEF + 7) / 8) * 8;
    localparam int SUM_W       = ADC_BITS_DEF + 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SEG_ITEMS   = 275;
    localparam int SAMPLE_MAX  = (1 << ADC_BITS_DEF) - 1;
    localparam logic [ADC_BITS_DEF-1:0] FULL_SCALE = ADC_BITS_DEF'(SAMPLE_MAX);
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic                err;
        logic                buzz;
        logic                green;
        logic                red;
        logic [MODE_W-1:0]   mode;
        logic [WEIGHT_W-1:0] net;
    } reading_t;

    class weigh_scoreboard;
        logic [CAL_W-1:0]           cal_mass;
        logic [ALARM_W-1:0]         alarm_on;
        logic [ALARM_W-1:0]         alarm_off;
        logic [MODE_W-1:0]          mode;
        logic [SUM_W-1:0]           sum;
        logic [CNT_W-1:0]           count;
        logic [SUM_W-1:0]           zero_ref;
        logic [SUM_W-1:0]           span_ref;
        logic signed [WEIGHT_W-1:0] tare;
        logic                       red;
        logic                       buzz;
        reading_t                   expected_readings[$];
        int                         errors;

        function new();
            cal_mass  = CAL_MASS_RST;
            alarm_on  = ALARM_ON_RST;
            alarm_off = ALARM_OFF_RST;
            mode      = M_IDLE;
            sum       = '0;
            count     = '0;
            zero_ref  = '0;
            span_ref  = '0;
            tare      = '0;
            red       = 1'b1;
            buzz      = 1'b0;
            errors    = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_CAL_MASS:  cal_mass  = value[CAL_W-1:0];
                REG_ALARM_ON:  alarm_on  = value[ALARM_W-1:0];
                REG_ALARM_OFF: alarm_off = value[ALARM_W-1:0];
                default: ;
            endcase
        endfunction

        function longint sat24(longint v);
            if (v > longint'(W_MAX))
                return longint'(W_MAX);
            if (v < longint'(W_MIN))
                return longint'(W_MIN);
            return v;
        endfunction

        function longint gross_of(logic [ADC_BITS_DEF-1:0] s);
            longint den;
            longint num;
            den = longint'(span_ref) - longint'(zero_ref);
            if (den == 0)
                return longint'(0);
            num = (longint'(s) * AVG_COUNT_DEF - longint'(zero_ref))
                  * longint'(cal_mass) * longint'(CG_PER_G);
            return sat24(num / den);
        endfunction

        function void note_tick(logic [ADC_BITS_DEF-1:0] s, logic act, logic rst);
            longint            gross;
            longint            net;
            logic              err;
            logic [MODE_W-1:0] m;
            reading_t          r;
            gross = gross_of(s);
            net   = sat24(gross - longint'(tare));
            err   = (span_ref == zero_ref);
            m     = mode;
            if (rst) begin
                m    = M_IDLE;
                red  = 1'b1;
                buzz = 1'b0;
            end
            else begin
                case (m)
                    M_IDLE: begin
                        red  = 1'b1;
                        buzz = 1'b0;
                        if (act) begin
                            sum   = '0;
                            count = '0;
                            m     = M_AVG_ZERO;
                        end
                    end
                    M_AVG_ZERO, M_AVG_SPAN: begin
                        red   = ~red;
                        buzz  = 1'b0;
                        sum   = sum + SUM_W'(s);
                        count = count + 1'b1;
                        if (count >= AVG_COUNT_DEF) begin
                            if (m == M_AVG_ZERO)
                                zero_ref = sum;
                            else
                                span_ref = sum;
                            sum   = '0;
                            count = '0;
                            m     = m + 1'b1;
                        end
                    end
                    M_WAIT_SPN: begin
                        red  = ~red;
                        buzz = 1'b0;
                        if (act) begin
                            sum   = '0;
                            count = '0;
                            m     = M_AVG_SPAN;
                        end
                    end
                    M_CONFIRM: begin
                        red  = ~red;
                        buzz = 1'b0;
                        if (act) begin
                            red = 1'b0;
                            m   = M_MEASURE;
                        end
                    end
                    M_MEASURE: begin
                        red  = 1'b0;
                        buzz = 1'b0;
                        if (act) begin
                            tare = gross[WEIGHT_W-1:0];
                            m    = M_TARE;
                        end
                        else if (net >= longint'(alarm_on)) begin
                            m = M_ALARM;
                        end
                    end
                    M_TARE: begin
                        red  = 1'b0;
                        buzz = 1'b0;
                        m    = M_MEASURE;
                    end
                    default: begin
                        if (net < longint'(alarm_off)) begin
                            red  = 1'b0;
                            buzz = 1'b0;
                            m    = M_MEASURE;
                        end
                        else begin
                            red  = ~red;
                            buzz = ~buzz;
                        end
                    end
                endcase
            end
            mode    = m;
            r.net   = net[WEIGHT_W-1:0];
            r.mode  = m;
            r.red   = red;
            r.green = (m == M_MEASURE) || (m == M_TARE);
            r.buzz  = buzz;
            r.err   = err;
            expected_readings.push_back(r);
        endfunction

        function void report(string field, longint want, longint got);
            errors++;
            $display("%0t %s expected %0d actual %0d", $time, field, want, got);
        endfunction

        function void check_reading(logic [31:0] d);
            reading_t want;
            reading_t got;
            if (expected_readings.size() == 0) begin
                errors++;
                $display("%0t unexpected result expected none actual %h", $time, d);
                return;
            end
            want = expected_readings.pop_front();
            got  = d[30:0];
            if (got.net !== want.net)
                report("net_weight_cg", longint'($signed(want.net)),
                       longint'($signed(got.net)));
            if (got.mode !== want.mode)
                report("mode_code", longint'(want.mode), longint'(got.mode));
            if (got.red !== want.red)
                report("red_led", longint'(want.red), longint'(got.red));
            if (got.green !== want.green)
                report("green_led", longint'(want.green), longint'(got.green));
            if (got.buzz !== want.buzz)
                report("alarm_drive", longint'(want.buzz), longint'(got.buzz));
            if (got.err !== want.err)
                report("cal_error", longint'(want.err), longint'(got.err));
            if (d[31] !== 1'b0)
                report("pad bit", longint'(0), longint'(d[31]));
        endfunction
    endclass

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [1:0]          s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [31:0]         m_tdata;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [APB_AW-1:0]   paddr    = '0;
    logic [APB_DW-1:0]   pwdata   = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    weigh_scoreboard sb;
    int              tx_idle_pct = 0;
    int              rx_idle_pct = 0;
    int unsigned     cycle_count = 0;
    int              zbase;
    int              sbase;
    int              noise;

    load_cell_scale_controller_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_reading(m_tdata);
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic logic [ADC_BITS_DEF-1:0] clamp_sample(int v);
        if (v < 0)
            return '0;
        if (v > SAMPLE_MAX)
            return FULL_SCALE;
        return v[ADC_BITS_DEF-1:0];
    endfunction

    function automatic logic [ADC_BITS_DEF-1:0] noisy_sample(int base);
        return clamp_sample(base + int'($urandom_range(0, 2 * noise)) - noise);
    endfunction

    // calibration flavor: equal references, inverted span, tiny span or a normal one
    task automatic pick_profile();
        int kind;
        kind  = $urandom_range(0, 7);
        zbase = $urandom_range(0, SAMPLE_MAX);
        noise = $urandom_range(0, 8);
        case (kind)
            0: begin
                sbase = zbase;
                noise = 0;
            end
            1: sbase = zbase - int'($urandom_range(50, 1500));
            2: begin
                sbase = zbase + 1;
                noise = 0;
            end
            default: sbase = zbase + int'($urandom_range(50, 1500));
        endcase
        sbase = int'(clamp_sample(sbase));
    endtask

    function automatic logic [ADC_BITS_DEF-1:0] load_sample();
        int lo;
        int hi;
        int pick;
        lo   = (zbase < sbase) ? zbase : sbase;
        hi   = (zbase < sbase) ? sbase : zbase;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return FULL_SCALE;
        if (pick < 4)
            return ADC_BITS_DEF'($urandom_range(0, SAMPLE_MAX));
        return clamp_sample(lo - 20 + int'($urandom_range(0, 2 * (hi - lo) + 40)));
    endfunction

    task automatic send_tick(logic [ADC_BITS_DEF-1:0] s, logic act, logic rst);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - ADC_BITS_DEF){1'b0}}, s};
        s_tuser  <= {rst, act};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_tick(s, act, rst);
    endtask

    task automatic send_load_tick();
        logic [ADC_BITS_DEF-1:0] s;
        logic                    act;
        logic                    rst;
        int                      r;
        s   = ADC_BITS_DEF'($urandom_range(0, SAMPLE_MAX));
        act = 1'b0;
        rst = 1'b0;
        case (sb.mode)
            M_IDLE: begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    act = 1'b1;
                    pick_profile();
                end
                else if (r < 70)
                begin
                    rst = 1'b1;
                    act = 1'($urandom_range(0, 1));
                end
            end
            M_AVG_ZERO: begin
                s   = noisy_sample(zbase);
                act = 1'($urandom_range(0, 1));
                rst = ($urandom_range(0, 1999) == 0);
            end
            M_AVG_SPAN: begin
                s   = noisy_sample(sbase);
                act = 1'($urandom_range(0, 1));
                rst = ($urandom_range(0, 1999) == 0);
            end
            M_WAIT_SPN, M_CONFIRM: begin
                act = ($urandom_range(0, 2) == 0);
                rst = ($urandom_range(0, 99) == 0);
            end
            default: begin
                s   = load_sample();
                act = ($urandom_range(0, 11) == 0);
                rst = ($urandom_range(0, 119) == 0);
            end
        endcase
        send_tick(s, act, rst);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(int seg);
        logic [31:0] on_level;
        case (seg)
            0: begin
                apb_write(REG_CAL_MASS, 32'd100);
                apb_write(REG_ALARM_ON, 32'd13000);
                apb_write(REG_ALARM_OFF, 32'd12000);
                apb_write(REG_UNUSED, $urandom);
            end
            1: begin
                apb_write(REG_CAL_MASS, 32'd1);
                apb_write(REG_ALARM_ON, 32'd0);
                apb_write(REG_ALARM_OFF, 32'd0);
            end
            2: begin
                apb_write(REG_CAL_MASS, 32'hFFFF_FFFF);
                apb_write(REG_ALARM_ON, 32'hFFFF_FFFF);
                apb_write(REG_ALARM_OFF, 32'hFFFF_FFFF);
            end
            3: begin
                apb_write(REG_CAL_MASS, 32'd0);
                apb_write(REG_ALARM_ON, 32'd0);
                apb_write(REG_ALARM_OFF, 32'h007F_FFFF);
            end
            4: begin
                on_level = $urandom_range(0, 50000);
                apb_write(REG_CAL_MASS, $urandom_range(1, 1000));
                apb_write(REG_ALARM_ON, on_level);
                apb_write(REG_ALARM_OFF, $urandom_range(0, on_level));
            end
            default: begin
                apb_write(REG_CAL_MASS, 32'd1000);
                apb_write(REG_ALARM_ON, 32'd20000);
                apb_write(REG_ALARM_OFF, 32'd100);
            end
        endcase
    endtask

    task automatic wait_drained();
        while (sb.expected_readings.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        pick_profile();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int seg = 0; seg < 6; seg++)
        begin
            case (seg / 2)
                0: begin
                    tx_idle_pct = 10;
                    rx_idle_pct = 85;
                end
                1: begin
                    tx_idle_pct = 85;
                    rx_idle_pct = 10;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            wait_drained();
            configure(seg);
            if (seg == 0)
            begin
                // idle with no calibration, reset button priority, abort of averaging
                send_tick('0, 1'b0, 1'b0);
                send_tick(FULL_SCALE, 1'b0, 1'b0);
                send_tick('0, 1'b1, 1'b1);
                send_tick(FULL_SCALE, 1'b0, 1'b1);
                send_tick(12'hAAA, 1'b1, 1'b0);
                send_tick(12'h555, 1'b1, 1'b0);
                send_tick(FULL_SCALE, 1'b0, 1'b0);
                send_tick(12'hFFF, 1'b0, 1'b1);
                send_tick(12'h7, 1'b1, 1'b1);
            end
            for (int i = 0; i < SEG_ITEMS; i++)
                send_load_tick();
            s_tvalid <= 1'b0;
        end
        wait_drained();
        repeat (64) @(posedge clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
